>>> sv/assert_macros.svh
// Assertion macros shared by the pair force RTL.
// Expects clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LJ_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LJ_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/ljpf_pkg.sv
// Shared types and constants of the Lennard-Jones pair force block.
// No dependencies.
`default_nettype none

package ljpf_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [63:0] SMAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] SMIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] UMAX = 64'hffff_ffff_ffff_ffff;
  localparam logic [63:0] ONE_Q = 64'h0000_0001_0000_0000;

  localparam logic [2:0] CFG_CUTOFF = 3'd0;
  localparam logic [2:0] CFG_SIGMA  = 3'd1;
  localparam logic [2:0] CFG_SHIFT  = 3'd2;
  localparam logic [2:0] CFG_EPS    = 3'd3;

  localparam logic [31:0] RST_CUTOFF = 32'd2195139;
  localparam logic [31:0] RST_SIGMA  = 32'd10087560;
  localparam logic [31:0] RST_SHIFT  = 32'hffff_fef5;
  localparam logic [31:0] RST_EPS    = 32'd10945;

  typedef struct packed {
    logic             ok;
    logic             last_atom;
    logic             last_frame;
    logic [63:0]      r2;
    logic [2:0][30:0] dmag;
    logic [2:0]       dneg;
  } pair_t;

  typedef struct packed {
    logic        go;
    logic        frac;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic        go;
    logic [63:0] d;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] q;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> sv/lennard_jones_pair_force.sv
// Top level of the Lennard-Jones 12-6 pair force block with shifted energy.
// Holds configuration registers; uses ljpf_pkg, ljpf_front, ljpf_fifo,
// ljpf_div, ljpf_mul and ljpf_back.
//
//  channel  direction  tdata (low bit up)                          tuser / tlast
//  in_      slave      pos_i_x pos_i_y pos_i_z pos_j_x pos_j_y     last_for_atom /
//                      pos_j_z (POS_WIDTH each)                    last_of_frame
//  out_     master     force_x force_y force_z atom_energy         - / frame_done
//                      total_energy (64 each)
//  cfg_     write      index 0..3, 32-bit data                     -
//
// Sequence: 3-stage front end feeds a 4-entry queue; a pair in range goes through
// the divide step and then ten passes of the shared 64x64 multiplier, while an
// out-of-range pair skips the divide step and these ten passes; a frame total adds
// one more multiplier pass for either kind of pair.
// Reset: synchronous active-low rst_n; accumulators clear, config takes defaults.
// Stalls: input stalls only on a full queue; the result register waits for
// out_tready while the front end keeps taking pairs.
`default_nettype none

module lennard_jones_pair_force #(
  parameter int POS_WIDTH = 32,
  parameter int FRAC_BITS = 16,
  localparam int IN_W = ((6*POS_WIDTH + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // pos_i_x, pos_i_y, pos_i_z, pos_j_x, pos_j_y, pos_j_z, zero pad
  input  logic [IN_W-1:0]  in_tdata,
  // last_for_atom
  input  logic             in_tuser,
  input  logic             in_tlast,
  output logic             out_tvalid,
  input  logic             out_tready,
  // force_x, force_y, force_z, atom_energy, total_energy
  output logic [319:0]     out_tdata,
  output logic             out_tlast,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_wdata
);

  logic [31:0] cutoff_r, sigma_r, shift_r, eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cutoff_r <= ljpf_pkg::RST_CUTOFF;
      sigma_r  <= ljpf_pkg::RST_SIGMA;
      shift_r  <= ljpf_pkg::RST_SHIFT;
      eps_r    <= ljpf_pkg::RST_EPS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ljpf_pkg::CFG_CUTOFF: cutoff_r <= cfg_wdata;
        ljpf_pkg::CFG_SIGMA:  sigma_r  <= cfg_wdata;
        ljpf_pkg::CFG_SHIFT:  shift_r  <= cfg_wdata;
        ljpf_pkg::CFG_EPS:    eps_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic               q_push, q_full, q_pop, q_empty;
  ljpf_pkg::pair_t    q_wdata, q_rdata;
  ljpf_pkg::mul_req_t mul_req;
  ljpf_pkg::mul_rsp_t mul_rsp;
  ljpf_pkg::div_req_t div_req;
  ljpf_pkg::div_rsp_t div_rsp;

  ljpf_front #(
    .POS_WIDTH (POS_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .pos        (in_tdata[6*POS_WIDTH-1:0]),
    .last_atom  (in_tuser),
    .last_frame (in_tlast),
    .cutoff     (cutoff_r),
    .push       (q_push),
    .wdata      (q_wdata),
    .full       (q_full)
  );

  ljpf_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  ljpf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ljpf_mul #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mul_req),
    .rsp   (mul_rsp)
  );

  ljpf_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_head       (q_rdata),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .sigma6       (sigma_r),
    .eshift       (shift_r),
    .eps          (eps_r),
    .mul_req      (mul_req),
    .mul_rsp      (mul_rsp),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .force_x      (out_tdata[63:0]),
    .force_y      (out_tdata[127:64]),
    .force_z      (out_tdata[191:128]),
    .atom_energy  (out_tdata[255:192]),
    .total_energy (out_tdata[319:256]),
    .frame_done   (out_tlast)
  );

endmodule

`default_nettype wire

>>> sv/ljpf_front.sv
// Front end: distance vector, squared distance and cutoff classification.
// Three stages with a common stall; depends on ljpf_pkg.
`default_nettype none

module ljpf_front #(
  parameter int POS_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [6*POS_WIDTH-1:0]   pos,
  input  logic                     last_atom,
  input  logic                     last_frame,
  input  logic [31:0]              cutoff,
  output logic                     push,
  output ljpf_pkg::pair_t          wdata,
  input  logic                     full
);

  logic [63:0] pi_c [3];
  logic [63:0] pj_c [3];
  logic [63:0] d_c  [3];
  logic [63:0] dm_c [3];
  logic [2:0]  far_c;

  logic             v1_r, v2_r, v3_r;
  logic [2:0][30:0] mag1_r, mag2_r, mag3_r;
  logic [2:0]       neg1_r, neg2_r, neg3_r;
  logic             far1_r, far2_r, far3_r;
  logic             la1_r, la2_r, la3_r;
  logic             lf1_r, lf2_r, lf3_r;
  logic [2:0][61:0] sq2_r;
  logic [63:0]      r2_3_r;
  logic [63:0]      cut_sh;
  logic             en;

  always_comb begin
    for (int m = 0; m < 3; m++) begin
      pi_c[m] = {{(64-POS_WIDTH){pos[m*POS_WIDTH+POS_WIDTH-1]}},
                 pos[m*POS_WIDTH +: POS_WIDTH]};
      pj_c[m] = {{(64-POS_WIDTH){pos[(m+3)*POS_WIDTH+POS_WIDTH-1]}},
                 pos[(m+3)*POS_WIDTH +: POS_WIDTH]};
      d_c[m]   = pi_c[m] - pj_c[m];
      dm_c[m]  = d_c[m][63] ? (64'd0 - d_c[m]) : d_c[m];
      far_c[m] = |dm_c[m][63:31];
    end
  end

  assign en       = !(v3_r && full);
  assign in_ready = en;
  assign push     = v3_r && !full;
  assign cut_sh   = 64'(cutoff) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int m = 0; m < 3; m++) begin
        mag1_r[m] <= dm_c[m][30:0];
        neg1_r[m] <= d_c[m][63];
        sq2_r[m]  <= 62'(mag1_r[m]) * 62'(mag1_r[m]);
      end
      far1_r <= |far_c;
      la1_r  <= last_atom;
      lf1_r  <= last_frame;

      mag2_r <= mag1_r;
      neg2_r <= neg1_r;
      far2_r <= far1_r;
      la2_r  <= la1_r;
      lf2_r  <= lf1_r;

      r2_3_r <= 64'(sq2_r[0]) + 64'(sq2_r[1]) + 64'(sq2_r[2]);
      mag3_r <= mag2_r;
      neg3_r <= neg2_r;
      far3_r <= far2_r;
      la3_r  <= la2_r;
      lf3_r  <= lf2_r;
    end
  end

  always_comb begin
    wdata.ok         = !far3_r && (r2_3_r != 64'd0) && (r2_3_r <= cut_sh);
    wdata.last_atom  = la3_r;
    wdata.last_frame = lf3_r;
    wdata.r2         = r2_3_r;
    wdata.dmag       = mag3_r;
    wdata.dneg       = neg3_r;
  end

endmodule

`default_nettype wire

>>> sv/ljpf_fifo.sv
// Short request queue between the front end and the back end.
// Register-based, depth from ljpf_pkg.
`default_nettype none
`include "assert_macros.svh"

module ljpf_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ljpf_pkg::pair_t wdata,
  output logic            full,
  input  logic            pop,
  output ljpf_pkg::pair_t rdata,
  output logic            empty
);

  ljpf_pkg::pair_t                mem_r [ljpf_pkg::QDEPTH];
  logic [ljpf_pkg::QAW-1:0]       wp_r, rp_r;
  logic [ljpf_pkg::QAW:0]         cnt_r;

  assign full  = (cnt_r == (ljpf_pkg::QAW+1)'(ljpf_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  `LJ_ASSERT_IMP(a_q_push_room, push, !full, "request pushed into full queue")
  `LJ_ASSERT_IMP(a_q_pop_data, pop, !empty, "request popped from empty queue")

endmodule

`default_nettype wire

>>> sv/ljpf_mul.sv
// Shared 64x64 unsigned multiplier, one 32x32 partial product per cycle.
// Returns (a*b)>>32 or (a*b)>>FRAC_BITS saturated to 64 bits; uses ljpf_pkg.
`default_nettype none
`include "assert_macros.svh"

module ljpf_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ljpf_pkg::mul_req_t req,
  output ljpf_pkg::mul_rsp_t rsp
);

  logic         busy_r, done_r, frac_r;
  logic [2:0]   cnt_r;
  logic [63:0]  a_r, b_r, pp_r;
  logic [1:0]   ppk_r;
  logic [127:0] acc_r;
  logic [31:0]  a_half, b_half;
  logic [127:0] placed;
  logic [63:0]  res32, resf;

  assign a_half = cnt_r[1] ? a_r[63:32] : a_r[31:0];
  assign b_half = cnt_r[0] ? b_r[63:32] : b_r[31:0];

  always_comb begin
    case (ppk_r) inside
      2'd0:       placed = {64'd0, pp_r};
      2'd1, 2'd2: placed = {32'd0, pp_r, 32'd0};
      default:    placed = {pp_r, 64'd0};
    endcase
  end

  assign res32 = (acc_r[127:96] != 32'd0) ? ljpf_pkg::UMAX : acc_r[95:32];
  assign resf  = (acc_r[127:64+FRAC_BITS] != '0) ? ljpf_pkg::UMAX
                                                  : acc_r[63+FRAC_BITS:FRAC_BITS];

  assign rsp.done = done_r;
  assign rsp.res  = frac_r ? resf : res32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 3'd4) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go && !busy_r) begin
      a_r    <= req.a;
      b_r    <= req.b;
      frac_r <= req.frac;
      acc_r  <= '0;
    end else if (busy_r) begin
      if (cnt_r != 3'd4) begin
        pp_r  <= 64'(a_half) * 64'(b_half);
        ppk_r <= cnt_r[1:0];
      end
      if (cnt_r != 3'd0) acc_r <= acc_r + placed;
    end
  end

  `LJ_ASSERT_IMP(a_mul_no_overlap, req.go, !busy_r, "multiply requested while busy")

endmodule

`default_nettype wire

>>> sv/ljpf_div.sv
// Restoring divider for 2^(32+2F) / r2, one quotient bit per cycle.
// Saturates to all ones; uses ljpf_pkg.
`default_nettype none

module ljpf_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ljpf_pkg::div_req_t req,
  output ljpf_pkg::div_rsp_t rsp
);

  localparam int           P      = 32 + 2*FRAC_BITS;
  localparam logic [127:0] NUM    = 128'd1 << P;
  localparam logic [63:0]  NUM_HI = NUM[127:64];
  localparam logic [63:0]  NUM_LO = NUM[63:0];

  logic        busy_r, done_r, sat_r;
  logic [5:0]  cnt_r;
  logic [63:0] rem_r, q_r, d_r;
  logic [64:0] rem2, diff;
  logic        ge;

  assign rem2 = {rem_r, NUM_LO[cnt_r]};
  assign diff = rem2 - {1'b0, d_r};
  assign ge   = (rem2 >= {1'b0, d_r});

  assign rsp.done = done_r;
  assign rsp.q    = sat_r ? ljpf_pkg::UMAX : q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.go && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= 6'd63;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == 6'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go && !busy_r) begin
      d_r   <= req.d;
      rem_r <= NUM_HI;
      q_r   <= '0;
      sat_r <= (NUM_HI >= req.d);
    end else if (busy_r) begin
      rem_r        <= ge ? diff[63:0] : rem2[63:0];
      q_r[cnt_r]   <= ge;
    end
  end

endmodule

`default_nettype wire

>>> sv/ljpf_back.sv
// Back end: sequencer over the divider and shared multiplier, accumulators
// and result register. Depends on ljpf_pkg, ljpf_mul and ljpf_div responses.
`default_nettype none
`include "assert_macros.svh"

module ljpf_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ljpf_pkg::pair_t    q_head,
  input  logic               q_empty,
  output logic               q_pop,
  input  logic [31:0]        sigma6,
  input  logic [31:0]        eshift,
  input  logic [31:0]        eps,
  output ljpf_pkg::mul_req_t mul_req,
  input  ljpf_pkg::mul_rsp_t mul_rsp,
  output ljpf_pkg::div_req_t div_req,
  input  ljpf_pkg::div_rsp_t div_rsp,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        force_x,
  output logic [63:0]        force_y,
  output logic [63:0]        force_z,
  output logic [63:0]        atom_energy,
  output logic [63:0]        total_energy,
  output logic               frame_done
);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_DIV  = 5'd1;
  localparam logic [4:0] ST_M1   = 5'd2;
  localparam logic [4:0] ST_M2   = 5'd3;
  localparam logic [4:0] ST_M3   = 5'd4;
  localparam logic [4:0] ST_M4   = 5'd5;
  localparam logic [4:0] ST_E1   = 5'd6;
  localparam logic [4:0] ST_E2   = 5'd7;
  localparam logic [4:0] ST_M5   = 5'd8;
  localparam logic [4:0] ST_M6   = 5'd9;
  localparam logic [4:0] ST_M7   = 5'd10;
  localparam logic [4:0] ST_FX   = 5'd11;
  localparam logic [4:0] ST_FY   = 5'd12;
  localparam logic [4:0] ST_FZ   = 5'd13;
  localparam logic [4:0] ST_END  = 5'd14;
  localparam logic [4:0] ST_MT   = 5'd15;
  localparam logic [4:0] ST_OUT  = 5'd16;

  localparam logic [63:0] K_LIMIT = ljpf_pkg::SMAX / 64'd12;
  localparam logic [63:0] SIX_ONE = 64'h0000_0006_0000_0000;

  function automatic logic [63:0] sat_signed(input logic [63:0] m, input logic neg);
    if (!neg) return m[63] ? ljpf_pkg::SMAX : m;
    return m[63] ? ljpf_pkg::SMIN : (64'd0 - m);
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? ljpf_pkg::SMIN : ljpf_pkg::SMAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? ljpf_pkg::SMIN : ljpf_pkg::SMAX;
    return s[63:0];
  endfunction

  logic [4:0]          st_r, st_prev_r;
  ljpf_pkg::pair_t     item_r;
  ljpf_pkg::mul_req_t  mreq_r;
  ljpf_pkg::div_req_t  dreq_r;
  logic [63:0]         inv_r, r6_r, ep_r, e_r, k_r, gmag_r, tot_r;
  logic                neg_r, gneg_r;
  logic [63:0]         fx_r, fy_r, fz_r, ae_r, fe_r;
  logic                ov_r, ofd_r;
  logic [63:0]         ox_r, oy_r, oz_r, oae_r, otot_r;

  logic [63:0] mres, sig_sh, epsq, shx, r6c, rm1, rm1_mag, esat, e_half, k_c;
  logic [63:0] a_s, kmag, gmag_c, fe_mag;
  logic        gneg_c, slot_free, mdone, mul_go, div_go;

  assign mres    = mul_rsp.res;
  assign mdone   = mul_rsp.done;
  assign sig_sh  = 64'(sigma6) << (32 - FRAC_BITS);
  assign epsq    = (64'(eps) << (32 - FRAC_BITS)) << 2;
  assign shx     = {{32{eshift[31]}}, eshift} << (32 - FRAC_BITS);
  assign r6c     = mres[63] ? ljpf_pkg::SMAX : mres;
  assign rm1     = r6c - ljpf_pkg::ONE_Q;
  assign rm1_mag = rm1[63] ? (64'd0 - rm1) : rm1;
  assign esat    = sat_sub(ep_r, shx);
  assign e_half  = {esat[63], esat[63:1]};
  assign k_c     = (r6_r > K_LIMIT) ? ljpf_pkg::SMAX
                                    : ((r6_r << 3) + (r6_r << 2) - SIX_ONE);
  assign a_s     = mres[63] ? ljpf_pkg::SMAX : mres;
  assign kmag    = k_r[63] ? (64'd0 - k_r) : k_r;
  assign gneg_c  = neg_r && (mres != 64'd0);
  assign gmag_c  = neg_r ? (mres[63] ? ljpf_pkg::SMIN : mres)
                         : (mres[63] ? ljpf_pkg::SMAX : mres);
  assign fe_mag  = fe_r[63] ? (64'd0 - fe_r) : fe_r;

  // issue a request on the first cycle of each wait state
  assign mul_go  = (st_r != st_prev_r) &&
                   (st_r inside {ST_M1, ST_M2, ST_M3, ST_M4, ST_M5, ST_M6, ST_M7,
                                 ST_FX, ST_FY, ST_FZ, ST_MT});
  assign div_go  = (st_r == ST_DIV) && (st_prev_r != ST_DIV);

  assign slot_free = !ov_r || out_ready;
  assign q_pop     = (st_r == ST_IDLE) && !q_empty;
  assign mul_req   = '{go: mul_go, frac: mreq_r.frac, a: mreq_r.a, b: mreq_r.b};
  assign div_req   = '{go: div_go, d: dreq_r.d};

  assign out_valid    = ov_r;
  assign force_x      = ox_r;
  assign force_y      = oy_r;
  assign force_z      = oz_r;
  assign atom_energy  = oae_r;
  assign total_energy = otot_r;
  assign frame_done   = ofd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_prev_r <= ST_IDLE;
      ov_r      <= 1'b0;
    end else begin
      st_prev_r <= st_r;
      if ((st_r == ST_OUT) && slot_free) begin
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_IDLE;
      mreq_r <= '0;
      dreq_r <= '0;
      fx_r   <= '0;
      fy_r   <= '0;
      fz_r   <= '0;
      ae_r   <= '0;
      fe_r   <= '0;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (!q_empty) begin
            item_r <= q_head;
            if (q_head.ok) begin
              dreq_r <= '{go: 1'b1, d: q_head.r2};
              st_r   <= ST_DIV;
            end else begin
              st_r <= ST_END;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            inv_r  <= div_rsp.q;
            mreq_r <= '{go: 1'b1, frac: 1'b0, a: div_rsp.q, b: div_rsp.q};
            st_r   <= ST_M1;
          end
        end
        ST_M1: begin
          if (mdone) begin
            mreq_r <= '{go: 1'b1, frac: 1'b0, a: inv_r, b: mres};
            st_r   <= ST_M2;
          end
        end
        ST_M2: begin
          if (mdone) begin
            mreq_r <= '{go: 1'b1, frac: 1'b0, a: sig_sh, b: mres};
            st_r   <= ST_M3;
          end
        end
        ST_M3: begin
          if (mdone) begin
            r6_r   <= r6c;
            neg_r  <= rm1[63];
            mreq_r <= '{go: 1'b1, frac: 1'b0, a: r6c, b: rm1_mag};
            st_r   <= ST_M4;
          end
        end
        ST_M4: begin
          if (mdone) begin
            ep_r <= sat_signed(mres, neg_r);
            st_r <= ST_E1;
          end
        end
        ST_E1: begin
          e_r  <= e_half;
          k_r  <= k_c;
          st_r <= ST_E2;
        end
        ST_E2: begin
          ae_r   <= sat_add(ae_r, e_r);
          fe_r   <= sat_add(fe_r, e_r);
          mreq_r <= '{go: 1'b1, frac: 1'b0, a: r6_r, b: inv_r};
          st_r   <= ST_M5;
        end
        ST_M5: begin
          if (mdone) begin
            mreq_r <= '{go: 1'b1, frac: 1'b0, a: epsq, b: mres};
            st_r   <= ST_M6;
          end
        end
        ST_M6: begin
          if (mdone) begin
            neg_r  <= k_r[63];
            mreq_r <= '{go: 1'b1, frac: 1'b0, a: a_s, b: kmag};
            st_r   <= ST_M7;
          end
        end
        ST_M7: begin
          if (mdone) begin
            gmag_r <= gmag_c;
            gneg_r <= gneg_c;
            neg_r  <= item_r.dneg[0] ^ gneg_c;
            mreq_r <= '{go: 1'b1, frac: 1'b1, a: 64'(item_r.dmag[0]), b: gmag_c};
            st_r   <= ST_FX;
          end
        end
        ST_FX: begin
          if (mdone) begin
            fx_r   <= sat_add(fx_r, sat_signed(mres, neg_r));
            neg_r  <= item_r.dneg[1] ^ gneg_r;
            mreq_r <= '{go: 1'b1, frac: 1'b1, a: 64'(item_r.dmag[1]), b: gmag_r};
            st_r   <= ST_FY;
          end
        end
        ST_FY: begin
          if (mdone) begin
            fy_r   <= sat_add(fy_r, sat_signed(mres, neg_r));
            neg_r  <= item_r.dneg[2] ^ gneg_r;
            mreq_r <= '{go: 1'b1, frac: 1'b1, a: 64'(item_r.dmag[2]), b: gmag_r};
            st_r   <= ST_FZ;
          end
        end
        ST_FZ: begin
          if (mdone) begin
            fz_r <= sat_add(fz_r, sat_signed(mres, neg_r));
            st_r <= ST_END;
          end
        end
        ST_END: begin
          if (item_r.last_atom || item_r.last_frame) begin
            if (item_r.last_frame) begin
              neg_r  <= fe_r[63];
              mreq_r <= '{go: 1'b1, frac: 1'b0, a: fe_mag, b: epsq};
              st_r   <= ST_MT;
            end else begin
              tot_r <= '0;
              st_r  <= ST_OUT;
            end
          end else begin
            st_r <= ST_IDLE;
          end
        end
        ST_MT: begin
          if (mdone) begin
            tot_r <= sat_signed(mres, neg_r);
            st_r  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (slot_free) begin
            ox_r   <= fx_r;
            oy_r   <= fy_r;
            oz_r   <= fz_r;
            oae_r  <= ae_r;
            otot_r <= tot_r;
            ofd_r  <= item_r.last_frame;
            fx_r   <= '0;
            fy_r   <= '0;
            fz_r   <= '0;
            ae_r   <= '0;
            if (item_r.last_frame) fe_r <= '0;
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  `LJ_ASSERT_NXT(a_frame_clear,
                 (st_r == ST_OUT) && slot_free && item_r.last_frame, fe_r == '0,
                 "frame energy not cleared after frame result")
  `LJ_ASSERT_IMP(a_div_owner, div_rsp.done, st_r == ST_DIV, "quotient returned outside divide state")

endmodule

`default_nettype wire
